[hw/rtl/f16da_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f16da_pkg
// Types, character codes and the serial binary-to-BCD step for the
// 16.16 fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package f16da_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_INT,
      ST_POINT,
      ST_FRAC
   } state_type;

   localparam int BIN_BITS   = 17;   // wide enough for ipart and scaled fraction
   localparam int BCD_DIGITS = 5;
   localparam int BCD_BITS   = 4 * BCD_DIGITS;

   localparam logic [16:0] FRAC_SCALE = 17'd100000;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // One double-dabble step: correct digits >= 5, then shift in a new bit.
   function automatic logic [BCD_BITS-1:0] dabble_shift(
      input logic [BCD_BITS-1:0] bcd,
      input logic                bit_in
   );
      logic [BCD_BITS-1:0] adj;
      adj = bcd;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (adj[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
         end
      end
      return {adj[BCD_BITS-2:0], bit_in};
   endfunction

endpackage

[hw/rtl/fixed16_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed16_to_decimal_ascii
// Signed 16.16 fixed-point value in, decimal ASCII text out, one character
// per transaction with last set on the final character.
// ----------------------------------------------------------------------------
// A value is captured, its fraction is scaled by 100000/65536, and then
// a 17-step serial binary-to-BCD shift converts integer and fraction side
// by side. Leading zeros of the integer are then suppressed, keeping at
// least one digit, and the text goes out at one character per cycle (1 to
// 12 characters) while the result side is not stalling. A new value is
// taken once the final character has been loaded into the output
// register.
// ----------------------------------------------------------------------------
module fixed16_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last
);

   localparam int BB = f16da_pkg::BIN_BITS;
   localparam int DB = f16da_pkg::BCD_BITS;

   f16da_pkg::state_type state_ff, state_in;

   logic          neg_ff, neg_in;
   logic          frac_nz_ff, frac_nz_in;
   logic [BB-1:0] int_bin_ff, int_bin_in;
   logic [BB-1:0] frac_bin_ff, frac_bin_in;
   logic [DB-1:0] int_bcd_ff, int_bcd_in;
   logic [DB-1:0] frac_bcd_ff, frac_bcd_in;
   logic [4:0]    bit_cnt_ff, bit_cnt_in;
   logic [2:0]    dig_cnt_ff, dig_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          emit;
   logic [31:0]   mag;
   logic [32:0]   product;
   logic [3:0]    int_top;
   logic [3:0]    frac_top;

   assign req_ready     = (state_ff == f16da_pkg::ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign emit          = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   assign mag      = req_value[31] ? (32'd0 - req_value) : req_value;
   assign product  = {17'd0, frac_bin_ff[15:0]} * {16'd0, f16da_pkg::FRAC_SCALE};
   assign int_top  = int_bcd_ff[DB-1 -: 4];
   assign frac_top = frac_bcd_ff[DB-1 -: 4];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         f16da_pkg::ST_IDLE: begin
            if (accept) state_in = f16da_pkg::ST_MUL;
         end
         f16da_pkg::ST_MUL: state_in = f16da_pkg::ST_CONV;
         f16da_pkg::ST_CONV: begin
            if (bit_cnt_ff == 5'd0) state_in = f16da_pkg::ST_SKIP;
         end
         f16da_pkg::ST_SKIP: begin
            if (!(int_top == 4'd0 && dig_cnt_ff > 3'd1)) begin
               state_in = neg_ff ? f16da_pkg::ST_SIGN : f16da_pkg::ST_INT;
            end
         end
         f16da_pkg::ST_SIGN: begin
            if (emit) state_in = f16da_pkg::ST_INT;
         end
         f16da_pkg::ST_INT: begin
            if (emit && dig_cnt_ff == 3'd1) begin
               state_in = frac_nz_ff ? f16da_pkg::ST_POINT : f16da_pkg::ST_IDLE;
            end
         end
         f16da_pkg::ST_POINT: begin
            if (emit) state_in = f16da_pkg::ST_FRAC;
         end
         f16da_pkg::ST_FRAC: begin
            if (emit && dig_cnt_ff == 3'd1) state_in = f16da_pkg::ST_IDLE;
         end
         default: state_in = f16da_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      neg_in       = neg_ff;
      frac_nz_in   = frac_nz_ff;
      int_bin_in   = int_bin_ff;
      frac_bin_in  = frac_bin_ff;
      int_bcd_in   = int_bcd_ff;
      frac_bcd_in  = frac_bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         f16da_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in      = req_value[31];
               frac_nz_in  = |mag[15:0];
               int_bin_in  = {1'b0, mag[31:16]};
               frac_bin_in = {1'b0, mag[15:0]};
               int_bcd_in  = '0;
               frac_bcd_in = '0;
            end
         end
         f16da_pkg::ST_MUL: begin
            frac_bin_in = product[32:16];
            bit_cnt_in  = 5'(BB - 1);
         end
         f16da_pkg::ST_CONV: begin
            int_bcd_in  = f16da_pkg::dabble_shift(int_bcd_ff, int_bin_ff[BB-1]);
            frac_bcd_in = f16da_pkg::dabble_shift(frac_bcd_ff, frac_bin_ff[BB-1]);
            int_bin_in  = {int_bin_ff[BB-2:0], 1'b0};
            frac_bin_in = {frac_bin_ff[BB-2:0], 1'b0};
            bit_cnt_in  = bit_cnt_ff - 5'd1;
            dig_cnt_in  = 3'(f16da_pkg::BCD_DIGITS);
         end
         f16da_pkg::ST_SKIP: begin
            // drop leading zero digits, keeping at least one
            if (int_top == 4'd0 && dig_cnt_ff > 3'd1) begin
               int_bcd_in = {int_bcd_ff[DB-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - 3'd1;
            end
         end
         f16da_pkg::ST_SIGN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = f16da_pkg::CH_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         f16da_pkg::ST_INT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = f16da_pkg::CH_ZERO + {4'd0, int_top};
               rsp_last_in  = (dig_cnt_ff == 3'd1) && !frac_nz_ff;
               int_bcd_in   = {int_bcd_ff[DB-5:0], 4'd0};
               dig_cnt_in   = dig_cnt_ff - 3'd1;
            end
         end
         f16da_pkg::ST_POINT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = f16da_pkg::CH_POINT;
               rsp_last_in  = 1'b0;
               dig_cnt_in   = 3'(f16da_pkg::BCD_DIGITS);
            end
         end
         f16da_pkg::ST_FRAC: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = f16da_pkg::CH_ZERO + {4'd0, frac_top};
               rsp_last_in  = (dig_cnt_ff == 3'd1);
               frac_bcd_in  = {frac_bcd_ff[DB-5:0], 4'd0};
               dig_cnt_in   = dig_cnt_ff - 3'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= f16da_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      frac_nz_ff  <= frac_nz_in;
      int_bin_ff  <= int_bin_in;
      frac_bin_ff <= frac_bin_in;
      int_bcd_ff  <= int_bcd_in;
      frac_bcd_ff <= frac_bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
